@@ design/gradient_colormap_defines.svh @@
`ifndef GRADIENT_COLORMAP_DEFINES_SVH
`define GRADIENT_COLORMAP_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define GCM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define GCM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/gcm_pkg.sv @@
package gcm_pkg;

  localparam int MAG_W      = 16;
  localparam int LEVEL_W    = 16;
  localparam int COLOR_W    = 32;
  localparam int CH_W       = 8;
  localparam int NUM_CH     = COLOR_W / CH_W;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int COUNT_W    = 3;
  localparam int STOP_W     = 2;
  localparam int FRAC_W     = 9;
  localparam int DIV_STAGES = 3;
  localparam int DIV_STEPS  = FRAC_W / DIV_STAGES;
  localparam int MAX_STOPS_DEF = 4;

  localparam logic [FRAC_W-1:0]     FRAC_ONE  = FRAC_W'(256);
  localparam logic [COUNT_W-1:0]    MIN_COUNT = COUNT_W'(2);

  localparam logic [COUNT_W-1:0]    RST_STOP_COUNT    = COUNT_W'(2);
  localparam logic [CFG_DATA_W-1:0] RST_STOP_LEVELS   = 64'h0000_0000_FFFF_0000;
  localparam logic [CFG_DATA_W-1:0] RST_COLORS_FIRST  = 64'hFFFF_FFFF_FF00_0000;
  localparam logic [CFG_DATA_W-1:0] RST_COLORS_SECOND = 64'h0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STOP_COUNT    = 3'd0,
    CFG_STOP_LEVELS   = 3'd1,
    CFG_COLORS_FIRST  = 3'd2,
    CFG_COLORS_SECOND = 3'd3
  } cfg_reg_t;

  // payload moving through the divider stages
  typedef struct packed {
    logic                 zero;
    logic [STOP_W-1:0]    j;
    logic [LEVEL_W:0]     rem;
    logic [LEVEL_W-1:0]   den;
    logic [FRAC_W-1:0]    quo;
  } div_t;

  function automatic logic [LEVEL_W-1:0] level_of(input logic [CFG_DATA_W-1:0] levels,
                                                  input logic [STOP_W-1:0] k);
    return levels[k*LEVEL_W +: LEVEL_W];
  endfunction

  function automatic logic [COLOR_W-1:0] color_of(input logic [CFG_DATA_W-1:0] first,
                                                  input logic [CFG_DATA_W-1:0] second,
                                                  input logic [STOP_W-1:0] k);
    logic [CFG_DATA_W-1:0] w;
    w = k[1] ? second : first;
    return w[k[0]*COLOR_W +: COLOR_W];
  endfunction

endpackage

@@ design/gcm_select.sv @@
module gcm_select #(
  parameter int MAX_STOPS = gcm_pkg::MAX_STOPS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic [gcm_pkg::MAG_W-1:0]      magnitude,
  input  logic [gcm_pkg::COUNT_W-1:0]    stop_count,
  input  logic [gcm_pkg::CFG_DATA_W-1:0] stop_levels,
  output logic                           valid_o,
  output gcm_pkg::div_t                  data_o
);
  import gcm_pkg::*;

  logic                 valid_r;
  div_t                 data_r;
  div_t                 data_nxt;
  logic [COUNT_W-1:0]   n;
  logic [LEVEL_W-1:0]   v;
  logic [LEVEL_W-1:0]   lo;
  logic [LEVEL_W-1:0]   hi;
  logic [LEVEL_W-1:0]   top_level;
  logic [STOP_W-1:0]    j;
  logic                 found;

  always_comb begin
    n = stop_count;
    if (n < MIN_COUNT) n = MIN_COUNT;
    if (n > COUNT_W'(MAX_STOPS)) n = COUNT_W'(MAX_STOPS);

    // clamp, upper bound last
    top_level = level_of(stop_levels, STOP_W'(n - COUNT_W'(1)));
    v = magnitude;
    if (v < level_of(stop_levels, '0)) v = level_of(stop_levels, '0);
    if (v > top_level) v = top_level;

    j = STOP_W'(n - COUNT_W'(1));
    found = 1'b0;
    for (int s = 1; s < MAX_STOPS; s++) begin
      if (!found && (COUNT_W'(s) < n) && (v <= level_of(stop_levels, STOP_W'(s)))) begin
        j = STOP_W'(s);
        found = 1'b1;
      end
    end

    lo = level_of(stop_levels, j - STOP_W'(1));
    hi = level_of(stop_levels, j);
    data_nxt.zero = (hi <= lo) || (v <= lo);
    data_nxt.j    = j;
    data_nxt.rem  = {1'b0, v - lo};
    data_nxt.den  = hi - lo;
    data_nxt.quo  = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;

endmodule

@@ design/gcm_divider.sv @@
module gcm_divider (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          valid_i,
  input  gcm_pkg::div_t data_i,
  output logic          valid_o,
  output gcm_pkg::div_t data_o
);
  import gcm_pkg::*;

  logic valid_r [DIV_STAGES];
  div_t stage_r [DIV_STAGES];
  div_t stage_nxt [DIV_STAGES];

  // restoring division, DIV_STEPS (three) quotient bits per stage
  function automatic div_t div_steps(input div_t d);
    div_t o;
    logic b;
    o = d;
    for (int i = 0; i < DIV_STEPS; i++) begin
      b = (o.rem >= {1'b0, o.den});
      if (b) o.rem = o.rem - {1'b0, o.den};
      o.quo = {o.quo[FRAC_W-2:0], b};
      o.rem = {o.rem[LEVEL_W-1:0], 1'b0};
    end
    return o;
  endfunction

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    if (g == 0) begin : g_first
      always_comb begin
        stage_nxt[g] = div_steps(data_i);
      end
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          valid_r[g] <= 1'b0;
        end else begin
          valid_r[g] <= valid_i;
        end
      end
    end else begin : g_rest
      always_comb begin
        stage_nxt[g] = div_steps(stage_r[g-1]);
      end
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          valid_r[g] <= 1'b0;
        end else begin
          valid_r[g] <= valid_r[g-1];
        end
      end
    end
    always_ff @(posedge clk) begin
      stage_r[g] <= stage_nxt[g];
    end
  end

  assign valid_o = valid_r[DIV_STAGES-1];
  assign data_o  = stage_r[DIV_STAGES-1];

endmodule

@@ design/gcm_blend.sv @@
module gcm_blend (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           valid_i,
  input  gcm_pkg::div_t                  data_i,
  input  logic [gcm_pkg::CFG_DATA_W-1:0] colors_first,
  input  logic [gcm_pkg::CFG_DATA_W-1:0] colors_second,
  output logic                           valid_o,
  output logic [gcm_pkg::COLOR_W-1:0]    color_o
);
  import gcm_pkg::*;

  logic                 valid_r;
  logic [COLOR_W-1:0]   color_r;
  logic [COLOR_W-1:0]   color_nxt;
  logic [FRAC_W-1:0]    f;
  logic [FRAC_W-1:0]    wl;
  logic [COLOR_W-1:0]   cl;
  logic [COLOR_W-1:0]   ch;
  logic [LEVEL_W:0]     sum [NUM_CH];

  always_comb begin
    f = data_i.quo;
    if (f > FRAC_ONE) f = FRAC_ONE;
    if (data_i.zero) f = '0;
    wl = FRAC_ONE - f;
    cl = color_of(colors_first, colors_second, data_i.j - STOP_W'(1));
    ch = color_of(colors_first, colors_second, data_i.j);
    for (int c = 0; c < NUM_CH; c++) begin
      sum[c] = (LEVEL_W+1)'(cl[c*CH_W +: CH_W]) * (LEVEL_W+1)'(wl)
             + (LEVEL_W+1)'(ch[c*CH_W +: CH_W]) * (LEVEL_W+1)'(f)
             + (LEVEL_W+1)'(128);
      color_nxt[c*CH_W +: CH_W] = sum[c][CH_W +: CH_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    color_r <= color_nxt;
  end

  assign valid_o = valid_r;
  assign color_o = color_r;

endmodule

@@ design/gradient_colormap.sv @@
// gradient_colormap: maps a 16-bit magnitude to a packed 32-bit colour by
// piecewise-linear interpolation between 2 to MAX_STOPS colour stops.
// input: pulse start with in_magnitude; a transaction is taken on every edge
//   with start high and busy low. busy is always low, so one transaction per
//   cycle is sustained, back to back.
// output: out_valid strobes for one cycle with out_pixel_color, after the
//   registers of interval select, three divider stages of three quotient
//   bits each and channel blend. results leave in input order.
// the receiver cannot stall; every result is shown once and never held.
// configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
//   is always high. index 0 stop count, 1 stop levels, 2 colours of stops
//   0 and 1, 3 colours of stops 2 and 3; other indexes are dropped. write
//   only with no transaction in flight.
// reset (rst_n low, synchronous): pipeline emptied, registers return to a
//   two-stop gradient from opaque black at 0 to opaque white at 65535.
module gradient_colormap #(
  parameter int MAX_STOPS = gcm_pkg::MAX_STOPS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [gcm_pkg::MAG_W-1:0]      in_magnitude,
  output logic                           out_valid,
  output logic [gcm_pkg::COLOR_W-1:0]    out_pixel_color,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [gcm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gcm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import gcm_pkg::*;

  logic [COUNT_W-1:0]    stop_count_r;
  logic [CFG_DATA_W-1:0] stop_levels_r;
  logic [CFG_DATA_W-1:0] colors_first_r;
  logic [CFG_DATA_W-1:0] colors_second_r;
  logic                  in_take;
  logic                  sel_valid;
  div_t                  sel_data;
  logic                  div_valid;
  div_t                  div_data;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign in_take   = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_count_r    <= RST_STOP_COUNT;
      stop_levels_r   <= RST_STOP_LEVELS;
      colors_first_r  <= RST_COLORS_FIRST;
      colors_second_r <= RST_COLORS_SECOND;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_STOP_COUNT:    stop_count_r    <= cfg_data[COUNT_W-1:0];
        CFG_STOP_LEVELS:   stop_levels_r   <= cfg_data;
        CFG_COLORS_FIRST:  colors_first_r  <= cfg_data;
        CFG_COLORS_SECOND: colors_second_r <= cfg_data;
        default: ;
      endcase
    end
  end

  gcm_select #(
    .MAX_STOPS (MAX_STOPS)
  ) u_select (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_take),
    .magnitude   (in_magnitude),
    .stop_count  (stop_count_r),
    .stop_levels (stop_levels_r),
    .valid_o     (sel_valid),
    .data_o      (sel_data)
  );

  gcm_divider u_divider (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (sel_valid),
    .data_i  (sel_data),
    .valid_o (div_valid),
    .data_o  (div_data)
  );

  gcm_blend u_blend (
    .clk           (clk),
    .rst_n         (rst_n),
    .valid_i       (div_valid),
    .data_i        (div_data),
    .colors_first  (colors_first_r),
    .colors_second (colors_second_r),
    .valid_o       (out_valid),
    .color_o       (out_pixel_color)
  );

endmodule

@@ design/gcm_checker.sv @@
`include "gradient_colormap_defines.svh"

module gcm_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic [gcm_pkg::MAG_W-1:0]   in_magnitude,
  input logic                        out_valid,
  input logic [gcm_pkg::COLOR_W-1:0] out_pixel_color
);

  // every transaction taken is followed by a result
  `GCM_ASSERT_NXT(a_result_follows, start && !busy, ##4 out_valid, "result missing")

  // no result without an earlier transaction taken
  `GCM_ASSERT_IMP(a_no_phantom, out_valid, $past(start && !busy, 5), "unexpected result")

  // equal magnitudes back to back give equal colours
  `GCM_ASSERT_IMP(a_same_in_same_out,
    out_valid && $past(out_valid) && ($past(in_magnitude, 5) == $past(in_magnitude, 6)),
    $stable(out_pixel_color), "colour differs for equal magnitude")

  // the block always takes a new transaction
  `GCM_ASSERT_IMP(a_never_busy, 1'b1, !busy, "busy raised")

endmodule

bind gradient_colormap gcm_checker u_gcm_checker (.*);

@@ dv/gradient_colormap_tb.sv @@
`timescale 1ns / 1ps

module gradient_colormap_tb;
  import gcm_pkg::*;

  localparam int MAX_STOPS       = MAX_STOPS_DEF;
  localparam int STALL_LIMIT     = 2000;
  localparam int SETTINGS_RUN    = 9;
  localparam int ITEMS_PER_SET   = 165;
  localparam int FIRST_SPARE_IDX = int'(CFG_COLORS_SECOND) + 1;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [MAG_W-1:0]      in_magnitude = '0;
  logic                  out_valid;
  logic [COLOR_W-1:0]    out_pixel_color;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // gradient registers as seen by the predictor
  logic [COUNT_W-1:0]    map_count;
  logic [CFG_DATA_W-1:0] map_levels;
  logic [CFG_DATA_W-1:0] map_first;
  logic [CFG_DATA_W-1:0] map_second;

  logic [MAG_W-1:0]   pending_magnitudes[$];
  logic [COLOR_W-1:0] expected_colours[$];

  logic in_taken  = 1'b0;
  logic cfg_taken = 1'b0;
  int   sender_idle_pct = 25;
  int   n_queued = 0;
  int   n_taken = 0;
  int   n_checked = 0;
  int   n_cfg_writes = 0;
  int   mismatches = 0;
  int   stall_cycles = 0;

  gradient_colormap dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_magnitude    (in_magnitude),
    .out_valid       (out_valid),
    .out_pixel_color (out_pixel_color),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [LEVEL_W-1:0] stop_level(input int k);
    return map_levels[k*LEVEL_W +: LEVEL_W];
  endfunction

  function automatic logic [COLOR_W-1:0] stop_colour(input int k);
    logic [CFG_DATA_W-1:0] w;
    w = (k >= 2) ? map_second : map_first;
    return w[(k % 2)*COLOR_W +: COLOR_W];
  endfunction

  function automatic logic [COLOR_W-1:0] blend_colour(input logic [MAG_W-1:0] mag);
    int          n, j, s;
    int unsigned v, lo, hi, f, a, b;
    logic [COLOR_W-1:0] cl, ch, res;
    logic        found;
    n = int'(map_count);
    if (n < 2) n = 2;
    if (n > MAX_STOPS) n = MAX_STOPS;
    v  = 32'(mag);
    lo = 32'(stop_level(0));
    hi = 32'(stop_level(n - 1));
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    j = n - 1;
    found = 1'b0;
    for (s = 1; s < n; s++) begin
      if (!found && v <= 32'(stop_level(s))) begin
        j = s;
        found = 1'b1;
      end
    end
    lo = 32'(stop_level(j - 1));
    hi = 32'(stop_level(j));
    if (hi <= lo || v <= lo) begin
      f = 0;
    end else begin
      f = ((v - lo) * 256) / (hi - lo);
      if (f > 256) f = 256;
    end
    cl = stop_colour(j - 1);
    ch = stop_colour(j);
    res = '0;
    for (s = 0; s < NUM_CH; s++) begin
      a = 32'(cl[s*CH_W +: CH_W]);
      b = 32'(ch[s*CH_W +: CH_W]);
      res[s*CH_W +: CH_W] = CH_W'((a * (256 - f) + b * f + 128) >> 8);
    end
    return res;
  endfunction

  // magnitudes cluster around the stop levels to hit interval edges
  function automatic logic [MAG_W-1:0] pick_magnitude();
    int               sel;
    logic [MAG_W-1:0] base;
    sel  = $urandom_range(99);
    base = stop_level($urandom_range(MAX_STOPS - 1));
    if (sel < 30) return MAG_W'($urandom);
    else if (sel < 55) return base + MAG_W'($urandom_range(16)) - MAG_W'(8);
    else if (sel < 70) return base;
    else if (sel < 80) return base + MAG_W'(1);
    else if (sel < 86) return base - MAG_W'(1);
    else if (sel < 93) return '0;
    else return '1;
  endfunction

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || in_taken) begin
      if (pending_magnitudes.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        in_magnitude <= pending_magnitudes.pop_front();
        start        <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    if (!rst_n) begin
      map_count  <= RST_STOP_COUNT;
      map_levels <= RST_STOP_LEVELS;
      map_first  <= RST_COLORS_FIRST;
      map_second <= RST_COLORS_SECOND;
      in_taken   <= 1'b0;
      cfg_taken  <= 1'b0;
    end else begin
      in_taken  <= start && !busy;
      cfg_taken <= cfg_valid && cfg_ready;
      if (start && !busy) begin
        expected_colours = {expected_colours, blend_colour(in_magnitude)};
        n_taken++;
      end
      if (cfg_valid && cfg_ready) begin
        n_cfg_writes++;
        case (cfg_index)
          CFG_STOP_COUNT:    map_count  <= cfg_data[COUNT_W-1:0];
          CFG_STOP_LEVELS:   map_levels <= cfg_data;
          CFG_COLORS_FIRST:  map_first  <= cfg_data;
          CFG_COLORS_SECOND: map_second <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid) begin
        if (expected_colours.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] unexpected colour %08h", $realtime, out_pixel_color);
        end else begin
          logic [COLOR_W-1:0] want;
          want = expected_colours.pop_front();
          n_checked++;
          if (out_pixel_color !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("[%0t] pixel_color mismatch: expected %08h, got %08h",
                       $realtime, want, out_pixel_color);
          end
        end
      end
      if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
          $display("Test completed with failures");
          $finish;
        end
      end
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(negedge clk); while (!cfg_taken);
  endtask

  task automatic drain();
    do @(negedge clk); while (n_taken != n_queued || expected_colours.size() != 0);
  endtask

  task automatic apply_setting(input int p);
    logic [LEVEL_W-1:0]    lv[4];
    logic [LEVEL_W-1:0]    t;
    logic [COUNT_W-1:0]    cnt;
    logic [CFG_DATA_W-1:0] c1, c2;
    int                    a, b;
    for (a = 0; a < 4; a++) lv[a] = LEVEL_W'($urandom);
    if (p != 5) begin
      for (a = 0; a < 3; a++)
        for (b = 0; b < 3 - a; b++)
          if (lv[b] > lv[b+1]) begin
            t = lv[b];
            lv[b] = lv[b+1];
            lv[b+1] = t;
          end
    end
    c1  = {$urandom, $urandom};
    c2  = {$urandom, $urandom};
    cnt = COUNT_W'(4);
    case (p)
      1: begin
        lv[0] = 16'h0000; lv[1] = 16'h4000; lv[2] = 16'hC000; lv[3] = 16'hFFFF;
      end
      2: begin
        cnt = COUNT_W'(3);
        c1  = 64'hFFFF_FFFF_0000_0000;
        c2  = 64'h0000_0000_FFFF_FFFF;
      end
      3: cnt = COUNT_W'(7);
      4: cnt = COUNT_W'(0);
      5: lv[2] = lv[1];                  // unordered and equal levels
      6: begin
        cnt   = COUNT_W'(1);
        lv[1] = lv[0];                   // zero width interval
      end
      7: begin
        cnt   = COUNT_W'(5);
        lv[0] = LEVEL_W'($urandom_range(65000));
        lv[1] = lv[0] + LEVEL_W'(1);
        lv[2] = lv[0] + LEVEL_W'(2);
        lv[3] = lv[0] + LEVEL_W'(3);
      end
      default: begin
        cnt   = COUNT_W'(2);
        lv[0] = 16'h0000;
        lv[1] = 16'hFFFF;
        c1    = 64'h0000_0000_FFFF_FFFF;
      end
    endcase
    @(negedge clk);
    if (p == 3 || p == 7)
      write_reg(CFG_IDX_W'(FIRST_SPARE_IDX + $urandom_range(3)), {$urandom, $urandom});
    write_reg(CFG_STOP_COUNT, CFG_DATA_W'(cnt));
    write_reg(CFG_STOP_LEVELS, {lv[3], lv[2], lv[1], lv[0]});
    write_reg(CFG_COLORS_FIRST, c1);
    write_reg(CFG_COLORS_SECOND, c2);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [MAG_W-1:0] directed[$];
    int               p, i;
    directed = '{16'h0000, 16'h0001, 16'h0002, 16'h007F, 16'h0080, 16'h00FF,
                 16'h0100, 16'h5555, 16'h7FFF, 16'h8000, 16'h8080, 16'hAAAA,
                 16'hFFFE, 16'hFFFF};
    repeat (6) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    @(negedge clk);
    foreach (directed[k]) begin
      pending_magnitudes = {pending_magnitudes, directed[k]};
      n_queued++;
    end
    for (p = 0; p < SETTINGS_RUN; p++) begin
      if (p > 0) apply_setting(p);
      sender_idle_pct = (p < 3) ? 25 : (p < 6) ? 85 : 0;
      for (i = 0; i < ITEMS_PER_SET; i++) begin
        pending_magnitudes = {pending_magnitudes, pick_magnitude()};
        n_queued++;
      end
      drain();
    end
    repeat (12) @(posedge clk);
    if (expected_colours.size() != 0) mismatches++;
    $display("%0d magnitudes mapped over %0d gradient settings (%0d register writes)",
             n_taken, SETTINGS_RUN, n_cfg_writes);
    $display("%0d colours checked, %0d mismatches", n_checked, mismatches);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+design
design/gcm_pkg.sv
design/gcm_select.sv
design/gcm_divider.sv
design/gcm_blend.sv
design/gradient_colormap.sv
design/gcm_checker.sv
dv/gradient_colormap_tb.sv
